>>> hdl/table_driven_fsm_engine_core_defines.svh
// Assertion macros for the FSM engine core.
// All assertions sample on clk and are off while rst_n is low.
`ifndef TABLE_DRIVEN_FSM_ENGINE_CORE_DEFINES_SVH
`define TABLE_DRIVEN_FSM_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TDFE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define TDFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define TDFE_ASSERT_IMPL(lbl, ante, cons)
`define TDFE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/tdfe_pkg.sv
package tdfe_pkg;

    // Fixed field widths
    localparam int ID_W     = 8;
    localparam int CMD_W    = 3;
    localparam int CAP_IN_W = 4;

    // Parameter defaults
    localparam int STATE_IDS_DEF       = 256;
    localparam int MAX_TRANSITIONS_DEF = 8;
    localparam int EVENT_BITS_DEF      = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_STEP      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_STATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_STATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD_TRANS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_TRANS = 3'd4;
    localparam logic [CMD_W-1:0] CMD_START     = 3'd5;

    // Status codes
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_IGNORED = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ID_W-1:0]     state_id;
        logic [ID_W-1:0]     event_req;
        logic [ID_W-1:0]     target;
        logic [CAP_IN_W-1:0] capacity;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0] current_state;
        logic            status;
    } result_t;

    // Row search outcome
    typedef struct packed {
        logic match_hit;
        logic free_slot;
        logic target_found;
    } row_flags_t;

endpackage

>>> hdl/table_driven_fsm_engine_core.sv
// Programmable transition-table FSM. The row is read at the accepting edge,
// compared and written back in the next cycle, and done pulses in the cycle after
// that. A new command is not taken until the previous one has executed (busy is
// high in S_EXEC). Results cannot be stalled by the receiver.
// After reset the state table is swept clear, with busy high during the sweep;
// configuration writes are taken during the sweep.
`include "table_driven_fsm_engine_core_defines.svh"

module table_driven_fsm_engine_core #(
    parameter int STATE_IDS       = tdfe_pkg::STATE_IDS_DEF,
    parameter int MAX_TRANSITIONS = tdfe_pkg::MAX_TRANSITIONS_DEF,
    parameter int EVENT_BITS      = tdfe_pkg::EVENT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  tdfe_pkg::request_t        request,
    output logic                      busy,
    output logic                      done,
    output tdfe_pkg::result_t         result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tdfe_pkg::ID_W-1:0] cfg_data
);

    localparam int ID_W   = tdfe_pkg::ID_W;
    localparam int CAP_W  = $clog2(MAX_TRANSITIONS + 1);
    localparam int CAPX_W = CAP_W + tdfe_pkg::CAP_IN_W;
    localparam int SLOT_W = EVENT_BITS + ID_W;
    localparam int ROW_W  = MAX_TRANSITIONS * SLOT_W;
    localparam int ADDR_W = $clog2(STATE_IDS);
    localparam int ST_W   = CAP_W + 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } fsm_state_t;

    fsm_state_t             state_reg, state_next;
    tdfe_pkg::request_t     req_reg, req_next;
    logic [ID_W-1:0]        look_id_reg, look_id_next;
    logic [ID_W-1:0]        cur_reg, cur_next;
    logic [ID_W-1:0]        start_state_reg, start_state_next;
    logic                   done_reg, done_next;
    tdfe_pkg::result_t      result_reg, result_next;
    logic                   clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;

    // Memories: per-state {present, capacity}, per-state slot row
    logic [ST_W-1:0]        state_mem [STATE_IDS];
    logic [ROW_W-1:0]       row_mem   [STATE_IDS];
    logic [ST_W-1:0]        st_rd_reg;
    logic [ROW_W-1:0]       row_rd_reg;

    logic                   accept;
    logic [ID_W-1:0]        rd_id;
    logic [ADDR_W+ID_W-1:0] rd_id_ext;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W+ID_W-1:0] look_ext;
    logic [ADDR_W-1:0]      exec_addr;

    logic                   st_we;
    logic [ADDR_W-1:0]      st_waddr;
    logic [ST_W-1:0]        st_wdata;
    logic                   row_we;
    logic [ROW_W-1:0]       row_wdata;

    logic                   in_range;
    logic                   present;
    logic [CAP_W-1:0]       cap_cur;
    logic [CAPX_W-1:0]      cap_ext;
    logic [CAPX_W-1:0]      cap_sat;
    logic [EVENT_BITS+ID_W-1:0] ev_ext;
    logic [EVENT_BITS-1:0]  event_key;

    tdfe_pkg::row_flags_t   flags;
    logic [ID_W-1:0]        step_target;
    logic [ROW_W-1:0]       add_row;
    logic [ROW_W-1:0]       del_row;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE) || clr_active_reg;
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // Lookup address: current state for a step, else the request's id
    assign rd_id     = (request.command == tdfe_pkg::CMD_STEP) ? cur_reg : request.state_id;
    assign rd_id_ext = {{ADDR_W{1'b0}}, rd_id};
    assign rd_addr   = rd_id_ext[ADDR_W-1:0];
    assign look_ext  = {{ADDR_W{1'b0}}, look_id_reg};
    assign exec_addr = look_ext[ADDR_W-1:0];

    // Decode of the fetched entry
    assign in_range  = 32'(look_id_reg) < 32'(STATE_IDS);
    assign present   = in_range && st_rd_reg[CAP_W];
    assign cap_cur   = st_rd_reg[CAP_W-1:0];
    assign ev_ext    = {{EVENT_BITS{1'b0}}, req_reg.event_req};
    assign event_key = ev_ext[EVENT_BITS-1:0];

    // Capacity clamp: zero becomes one, large values saturate
    assign cap_ext = CAPX_W'(req_reg.capacity);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            cap_sat = CAPX_W'(1);
        end
        else if (cap_ext > CAPX_W'(MAX_TRANSITIONS))
        begin
            cap_sat = CAPX_W'(MAX_TRANSITIONS);
        end
        else
        begin
            cap_sat = cap_ext;
        end
    end

    tdfe_row_ops #(
        .MAX_TRANSITIONS (MAX_TRANSITIONS),
        .EVENT_BITS      (EVENT_BITS)
    ) u_row_ops (
        .row         (row_rd_reg),
        .cap         (cap_cur),
        .event_key   (event_key),
        .target      (req_reg.target),
        .flags       (flags),
        .step_target (step_target),
        .add_row     (add_row),
        .del_row     (del_row)
    );

    // Command execution and next-state logic
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        look_id_next     = look_id_reg;
        cur_next         = cur_reg;
        start_state_next = start_state_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        clr_active_next  = clr_active_reg;
        clr_addr_next    = clr_addr_reg;
        st_we            = 1'b0;
        st_waddr         = exec_addr;
        st_wdata         = st_rd_reg;
        row_we           = 1'b0;
        row_wdata        = add_row;

        if (cfg_valid && cfg_ready)
        begin
            start_state_next = cfg_data;
        end

        // Sweep the state table clear after reset
        if (clr_active_reg)
        begin
            st_we    = 1'b1;
            st_waddr = clr_addr_reg;
            st_wdata = '0;
            if (clr_addr_reg == ADDR_W'(STATE_IDS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next     = request;
                    look_id_next = rd_id;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                logic status;
                status     = tdfe_pkg::ST_IGNORED;
                state_next = S_IDLE;
                unique case (req_reg.command)
                    tdfe_pkg::CMD_STEP:
                    begin
                        if (look_id_reg == '0)
                        begin
                            status = tdfe_pkg::ST_IGNORED;
                        end
                        else if (!present)
                        begin
                            cur_next = '0;
                        end
                        else
                        begin
                            if (flags.match_hit)
                            begin
                                cur_next = step_target;
                            end
                            status = tdfe_pkg::ST_DONE;
                        end
                    end
                    tdfe_pkg::CMD_ADD_STATE:
                    begin
                        if (in_range && !st_rd_reg[CAP_W])
                        begin
                            st_we     = 1'b1;
                            st_wdata  = {1'b1, cap_sat[CAP_W-1:0]};
                            row_we    = 1'b1;
                            row_wdata = '0;
                            status    = tdfe_pkg::ST_DONE;
                        end
                    end
                    tdfe_pkg::CMD_DEL_STATE:
                    begin
                        if (present)
                        begin
                            st_we    = 1'b1;
                            st_wdata = {1'b0, cap_cur};
                            status   = tdfe_pkg::ST_DONE;
                        end
                    end
                    tdfe_pkg::CMD_ADD_TRANS:
                    begin
                        if (present && (req_reg.target != '0) && flags.free_slot)
                        begin
                            row_we    = 1'b1;
                            row_wdata = add_row;
                            status    = tdfe_pkg::ST_DONE;
                        end
                    end
                    tdfe_pkg::CMD_DEL_TRANS:
                    begin
                        if (present && (req_reg.target != '0) && flags.target_found)
                        begin
                            row_we    = 1'b1;
                            row_wdata = del_row;
                            status    = tdfe_pkg::ST_DONE;
                        end
                    end
                    tdfe_pkg::CMD_START:
                    begin
                        cur_next = start_state_reg;
                        status   = tdfe_pkg::ST_DONE;
                    end
                    default:
                    begin
                        status = tdfe_pkg::ST_IGNORED;
                    end
                endcase
                done_next                 = 1'b1;
                result_next.current_state = cur_next;
                result_next.status        = status;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            req_reg         <= '0;
            look_id_reg     <= '0;
            cur_reg         <= '0;
            start_state_reg <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
            clr_active_reg  <= 1'b1;
            clr_addr_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            req_reg         <= req_next;
            look_id_reg     <= look_id_next;
            cur_reg         <= cur_next;
            start_state_reg <= start_state_next;
            done_reg        <= done_next;
            result_reg      <= result_next;
            clr_active_reg  <= clr_active_next;
            clr_addr_reg    <= clr_addr_next;
        end
    end

    // State table memory
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            state_mem[st_waddr] <= st_wdata;
        end
        if (accept)
        begin
            st_rd_reg <= state_mem[rd_addr];
        end
    end

    // Slot row memory
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[exec_addr] <= row_wdata;
        end
        if (accept)
        begin
            row_rd_reg <= row_mem[rd_addr];
        end
    end

    // Checks
    `TDFE_ASSERT_NEXT(a_accept_busy, accept, busy && !done)
    `TDFE_ASSERT_NEXT(a_single_result, done, !done)
    `TDFE_ASSERT_IMPL(a_done_after_exec, done, $past(state_reg == S_EXEC))
    `TDFE_ASSERT_IMPL(a_no_write_during_clear, clr_active_reg, !row_we && (state_reg == S_IDLE))

endmodule

>>> hdl/tdfe_row_ops.sv
module tdfe_row_ops #(
    parameter int MAX_TRANSITIONS = tdfe_pkg::MAX_TRANSITIONS_DEF,
    parameter int EVENT_BITS      = tdfe_pkg::EVENT_BITS_DEF
) (
    input  logic [MAX_TRANSITIONS*(EVENT_BITS+tdfe_pkg::ID_W)-1:0] row,
    input  logic [$clog2(MAX_TRANSITIONS+1)-1:0]                   cap,
    input  logic [EVENT_BITS-1:0]                                  event_key,
    input  logic [tdfe_pkg::ID_W-1:0]                              target,
    output tdfe_pkg::row_flags_t                                   flags,
    output logic [tdfe_pkg::ID_W-1:0]                              step_target,
    output logic [MAX_TRANSITIONS*(EVENT_BITS+tdfe_pkg::ID_W)-1:0] add_row,
    output logic [MAX_TRANSITIONS*(EVENT_BITS+tdfe_pkg::ID_W)-1:0] del_row
);

    localparam int CAP_W  = $clog2(MAX_TRANSITIONS + 1);
    localparam int SLOT_W = EVENT_BITS + tdfe_pkg::ID_W;
    localparam int ROW_W  = MAX_TRANSITIONS * SLOT_W;

    logic [MAX_TRANSITIONS-1:0] hit_vec;
    logic [MAX_TRANSITIONS-1:0] free_vec;
    logic [MAX_TRANSITIONS-1:0] tgt_vec;
    logic [MAX_TRANSITIONS-1:0] hit_first;
    logic [MAX_TRANSITIONS-1:0] free_first;
    logic [MAX_TRANSITIONS-1:0] from_match;
    logic [ROW_W+SLOT_W-1:0]    row_ext;
    logic [ROW_W-1:0]           row_shift;

    // Row moved down one slot, zero filled at the top
    assign row_ext   = {{SLOT_W{1'b0}}, row};
    assign row_shift = row_ext[ROW_W+SLOT_W-1:SLOT_W];

    // Per-slot compares
    always_comb
    begin
        logic [SLOT_W-1:0]          slot;
        logic                       in_cap;
        logic                       seen_hit;
        logic                       seen_free;
        logic                       seen_tgt;
        for (int j = 0; j < MAX_TRANSITIONS; j++)
        begin
            slot        = row[j*SLOT_W +: SLOT_W];
            in_cap      = CAP_W'(j) < cap;
            hit_vec[j]  = in_cap && (slot[tdfe_pkg::ID_W-1:0] != '0)
                          && (slot[SLOT_W-1:tdfe_pkg::ID_W] == event_key);
            free_vec[j] = in_cap && (slot[tdfe_pkg::ID_W-1:0] == '0);
            tgt_vec[j]  = in_cap && (slot[tdfe_pkg::ID_W-1:0] == target);
        end
        // Priority picks and prefix of the delete match
        seen_hit  = 1'b0;
        seen_free = 1'b0;
        seen_tgt  = 1'b0;
        for (int j = 0; j < MAX_TRANSITIONS; j++)
        begin
            hit_first[j]  = hit_vec[j] && !seen_hit;
            free_first[j] = free_vec[j] && !seen_free;
            seen_hit      = seen_hit | hit_vec[j];
            seen_free     = seen_free | free_vec[j];
            seen_tgt      = seen_tgt | tgt_vec[j];
            from_match[j] = seen_tgt;
        end
    end

    assign flags.match_hit    = |hit_vec;
    assign flags.free_slot    = |free_vec;
    assign flags.target_found = |tgt_vec;

    // Target of the first matching slot
    always_comb
    begin
        step_target = '0;
        for (int j = 0; j < MAX_TRANSITIONS; j++)
        begin
            if (hit_first[j])
            begin
                step_target = row[j*SLOT_W +: tdfe_pkg::ID_W];
            end
        end
    end

    // Insert into first free slot; compact after removal
    always_comb
    begin
        for (int j = 0; j < MAX_TRANSITIONS; j++)
        begin
            if (free_first[j])
            begin
                add_row[j*SLOT_W +: SLOT_W] = {event_key, target};
            end
            else
            begin
                add_row[j*SLOT_W +: SLOT_W] = row[j*SLOT_W +: SLOT_W];
            end

            if (from_match[j] && (CAP_W'(j + 1) < cap))
            begin
                del_row[j*SLOT_W +: SLOT_W] = row_shift[j*SLOT_W +: SLOT_W];
            end
            else if (from_match[j] && (CAP_W'(j + 1) == cap))
            begin
                del_row[j*SLOT_W +: SLOT_W] = '0;
            end
            else
            begin
                del_row[j*SLOT_W +: SLOT_W] = row[j*SLOT_W +: SLOT_W];
            end
        end
    end

endmodule

>>> tb/table_driven_fsm_engine_core_test.sv
`timescale 1ns / 1ps

module table_driven_fsm_engine_core_test;

    localparam int ID_W     = tdfe_pkg::ID_W;
    localparam int CMD_W    = tdfe_pkg::CMD_W;
    localparam int CAP_IN_W = tdfe_pkg::CAP_IN_W;

    // Reserved command codes, decoded as no-ops
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int NUM_IDS        = tdfe_pkg::STATE_IDS_DEF;
    localparam int ROW_SLOTS      = tdfe_pkg::MAX_TRANSITIONS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    logic               clk;
    logic               rst_n;
    logic               start;
    tdfe_pkg::request_t request;
    logic               busy;
    logic               done;
    tdfe_pkg::result_t  result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [ID_W-1:0]    cfg_data;

    // Shadow copy of the engine: state table, rows and current state
    logic            defined    [0:NUM_IDS-1];
    logic [3:0]      row_size   [0:NUM_IDS-1];
    logic [ID_W-1:0] row_event  [0:NUM_IDS-1][0:ROW_SLOTS-1];
    logic [ID_W-1:0] row_target [0:NUM_IDS-1][0:ROW_SLOTS-1];
    logic [ID_W-1:0] fsm_state;
    logic [ID_W-1:0] start_reg;

    tdfe_pkg::result_t pending_results [$];
    tdfe_pkg::result_t checked_result;
    int                mismatch_count;
    int                idle_cycles;

    // Random id / event pools so that steps hit defined states and transitions
    logic [ID_W-1:0] id_pool    [0:7];
    logic [ID_W-1:0] event_pool [0:3];

    table_driven_fsm_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Next state and status of the engine for one command
    function automatic tdfe_pkg::result_t apply_command(input tdfe_pkg::request_t r);
        tdfe_pkg::result_t res;
        int                id;
        int                n;
        int                i;
        int                pos;
        logic              stop;
        logic [3:0]        cap;
        res.status = tdfe_pkg::ST_IGNORED;
        id = int'(r.state_id);
        case (r.command)
            tdfe_pkg::CMD_STEP:
            begin
                if (fsm_state == '0)
                    res.status = tdfe_pkg::ST_IGNORED;
                else if (!defined[fsm_state])
                    fsm_state = '0;
                else
                begin
                    id   = int'(fsm_state);
                    n    = int'(row_size[id]);
                    stop = 1'b0;
                    for (i = 0; i < n; i++)
                    begin
                        if (!stop)
                        begin
                            if (row_target[id][i] == '0)
                                stop = 1'b1;
                            else if (row_event[id][i] == r.event_req)
                            begin
                                fsm_state = row_target[id][i];
                                stop = 1'b1;
                            end
                        end
                    end
                    res.status = tdfe_pkg::ST_DONE;
                end
            end
            tdfe_pkg::CMD_ADD_STATE:
            begin
                if (!defined[id])
                begin
                    cap = r.capacity;
                    if (cap == 4'd0)
                        cap = 4'd1;
                    if (cap > 4'(ROW_SLOTS))
                        cap = 4'(ROW_SLOTS);
                    defined[id]  = 1'b1;
                    row_size[id] = cap;
                    for (i = 0; i < ROW_SLOTS; i++)
                    begin
                        row_event[id][i]  = '0;
                        row_target[id][i] = '0;
                    end
                    res.status = tdfe_pkg::ST_DONE;
                end
            end
            tdfe_pkg::CMD_DEL_STATE:
            begin
                if (defined[id])
                begin
                    defined[id] = 1'b0;
                    res.status  = tdfe_pkg::ST_DONE;
                end
            end
            tdfe_pkg::CMD_ADD_TRANS:
            begin
                if (defined[id] && r.target != '0)
                begin
                    n   = int'(row_size[id]);
                    pos = -1;
                    for (i = 0; i < n; i++)
                        if (pos < 0 && row_target[id][i] == '0)
                            pos = i;
                    if (pos >= 0)
                    begin
                        row_target[id][pos] = r.target;
                        row_event[id][pos]  = r.event_req;
                        res.status = tdfe_pkg::ST_DONE;
                    end
                end
            end
            tdfe_pkg::CMD_DEL_TRANS:
            begin
                if (defined[id] && r.target != '0)
                begin
                    n   = int'(row_size[id]);
                    pos = -1;
                    for (i = 0; i < n; i++)
                        if (pos < 0 && row_target[id][i] == r.target)
                            pos = i;
                    if (pos >= 0)
                    begin
                        // shift the tail down to keep the row compact
                        for (i = pos; i < n - 1; i++)
                        begin
                            row_event[id][i]  = row_event[id][i + 1];
                            row_target[id][i] = row_target[id][i + 1];
                        end
                        row_event[id][n - 1]  = '0;
                        row_target[id][n - 1] = '0;
                        res.status = tdfe_pkg::ST_DONE;
                    end
                end
            end
            tdfe_pkg::CMD_START:
            begin
                fsm_state  = start_reg;
                res.status = tdfe_pkg::ST_DONE;
            end
            default:
                res.status = tdfe_pkg::ST_IGNORED;
        endcase
        res.current_state = fsm_state;
        return res;
    endfunction

    function automatic tdfe_pkg::request_t make_request(
        input logic [CMD_W-1:0]    cmd,
        input logic [ID_W-1:0]     sid,
        input logic [ID_W-1:0]     ev,
        input logic [ID_W-1:0]     tgt,
        input logic [CAP_IN_W-1:0] cap
    );
        tdfe_pkg::request_t r;
        r.command   = cmd;
        r.state_id  = sid;
        r.event_req = ev;
        r.target    = tgt;
        r.capacity  = cap;
        return r;
    endfunction

    // Mostly pool-based commands, some fully random noise
    function automatic tdfe_pkg::request_t random_request();
        tdfe_pkg::request_t r;
        int                 w;
        w = $urandom_range(99);
        if (w < 35)
            r.command = tdfe_pkg::CMD_STEP;
        else if (w < 47)
            r.command = tdfe_pkg::CMD_ADD_STATE;
        else if (w < 51)
            r.command = tdfe_pkg::CMD_DEL_STATE;
        else if (w < 76)
            r.command = tdfe_pkg::CMD_ADD_TRANS;
        else if (w < 86)
            r.command = tdfe_pkg::CMD_DEL_TRANS;
        else if (w < 94)
            r.command = tdfe_pkg::CMD_START;
        else
            r.command = ($urandom_range(1) == 0) ? CMD_RSVD_6 : CMD_RSVD_7;
        r.state_id  = ($urandom_range(99) < 85) ? id_pool[$urandom_range(7)]
                                                : ID_W'($urandom);
        r.event_req = ($urandom_range(99) < 75) ? event_pool[$urandom_range(3)]
                                                : ID_W'($urandom);
        w = $urandom_range(99);
        if (w < 10)
            r.target = '0;
        else if (w < 80)
            r.target = id_pool[$urandom_range(7)];
        else
            r.target = ID_W'($urandom);
        r.capacity = CAP_IN_W'($urandom_range(15));
        return r;
    endfunction

    task automatic refresh_pools();
        int i;
        for (i = 0; i < 8; i++)
            id_pool[i] = ID_W'($urandom_range(1, 255));
        id_pool[7] = 8'd255;
        if ($urandom_range(3) == 0)
            id_pool[6] = 8'd0;
        event_pool[0] = 8'd0;
        event_pool[1] = 8'd255;
        event_pool[2] = ID_W'($urandom);
        event_pool[3] = ID_W'($urandom);
    endtask

    // One request, held until accepted; start stays high afterwards
    task automatic send_request(input tdfe_pkg::request_t r);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_command(r));
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write; callers are to call it only with the engine idle, which the task does not check
    task automatic write_start_state(input logic [ID_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        start_reg = value;
    endtask

    task automatic run_random(input int count, input int pct, input logic mid_drain);
        int k;
        for (k = 0; k < count; k++)
        begin
            send_request(random_request());
            sender_gap(pct);
            if (mid_drain && k == count / 2)
                drain_results();
        end
    endtask

    task automatic test_directed();
        write_start_state(8'd255);
        // step with no current state
        send_request(make_request(tdfe_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, 4'd0));
        // capacity 0 -> 1, duplicate add, capacity saturation
        send_request(make_request(tdfe_pkg::CMD_ADD_STATE, 8'd255, 8'd0, 8'd0, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_ADD_STATE, 8'd255, 8'd0, 8'd0, 4'd3));
        send_request(make_request(tdfe_pkg::CMD_ADD_STATE, 8'd1, 8'd0, 8'd0, 4'd15));
        send_request(make_request(tdfe_pkg::CMD_ADD_TRANS, 8'd255, 8'd0, 8'd1, 4'd0));
        // full row, zero target, absent state
        send_request(make_request(tdfe_pkg::CMD_ADD_TRANS, 8'd255, 8'd5, 8'd2, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_ADD_TRANS, 8'd1, 8'd7, 8'd0, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_ADD_TRANS, 8'd7, 8'd7, 8'd1, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_ADD_TRANS, 8'd1, 8'd255, 8'd255, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_ADD_TRANS, 8'd1, 8'd9, 8'd1, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_START, 8'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, 4'd0));
        // no match keeps the state
        send_request(make_request(tdfe_pkg::CMD_STEP, 8'd0, 8'd3, 8'd0, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_STEP, 8'd0, 8'd255, 8'd0, 4'd0));
        // delete transition: no match, compacting hit, absent and zero target
        send_request(make_request(tdfe_pkg::CMD_DEL_TRANS, 8'd1, 8'd0, 8'd77, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_DEL_TRANS, 8'd1, 8'd0, 8'd255, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_DEL_TRANS, 8'd0, 8'd0, 8'd1, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_DEL_TRANS, 8'd1, 8'd0, 8'd0, 4'd0));
        // deleting the current state, then stepping from an undefined one
        send_request(make_request(tdfe_pkg::CMD_DEL_STATE, 8'd9, 8'd0, 8'd0, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_DEL_STATE, 8'd255, 8'd0, 8'd0, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(CMD_RSVD_6, 8'hFF, 8'hFF, 8'hFF, 4'hF));
        send_request(make_request(CMD_RSVD_7, 8'hFF, 8'hFF, 8'hFF, 4'hF));
        drain_results();
        write_start_state(8'd0);
        send_request(make_request(tdfe_pkg::CMD_START, 8'd0, 8'd0, 8'd0, 4'd0));
        send_request(make_request(tdfe_pkg::CMD_STEP, 8'd0, 8'd0, 8'd0, 4'd0));
    endtask

    task automatic test_no_idle();
        drain_results();
        refresh_pools();
        write_start_state(id_pool[0]);
        run_random(650, 0, 1'b0);
    endtask

    task automatic test_sender_idle();
        drain_results();
        refresh_pools();
        write_start_state(8'd255);
        run_random(600, 47, 1'b0);
    endtask

    // 33% idle, with a full pause for every result mid-phase
    task automatic test_mixed_idle();
        drain_results();
        refresh_pools();
        write_start_state(id_pool[$urandom_range(7)]);
        run_random(600, 33, 1'b1);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result: state %0d status %0d",
                             result.current_state, result.status);
                mismatch_count++;
            end
            else
            begin
                checked_result = pending_results.pop_front();
                if (result.current_state !== checked_result.current_state ||
                    result.status !== checked_result.status)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("mismatch: state exp %0d got %0d, status exp %0d got %0d",
                                 checked_result.current_state, result.current_state,
                                 checked_result.status, result.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[table_driven_fsm_engine_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int i;
        int j;
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        fsm_state      = '0;
        start_reg      = '0;
        for (i = 0; i < NUM_IDS; i++)
        begin
            defined[i]  = 1'b0;
            row_size[i] = '0;
            for (j = 0; j < ROW_SLOTS; j++)
            begin
                row_event[i][j]  = '0;
                row_target[i][j] = '0;
            end
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_mixed_idle();

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[table_driven_fsm_engine_core] OK");
        else
            $display("[table_driven_fsm_engine_core] ERROR");
        $finish;
    end

endmodule
